// File: rtl/core/mer_pkg.sv
// Shared widths, codes and command/status types for the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int COORD_BITS  = 12;
  localparam int AXIS_BITS   = COORD_BITS - 1;
  localparam int POINT_BITS  = COORD_BITS + 2;
  localparam int STEP_X_BITS = COORD_BITS;
  localparam int STEP_Y_BITS = COORD_BITS + 1;
  localparam int SQ_BITS     = 2 * AXIS_BITS;
  localparam int MUL_W       = 2 * COORD_BITS + 3;
  localparam int DEC_BITS    = 4 * COORD_BITS;
  localparam int YW          = STEP_Y_BITS + 2;
  localparam int COLOR_BITS  = 32;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // Operand pairs of the shared multiplier.
  typedef enum logic [3:0] {
    MS_NONE,
    MS_AA,
    MS_BB,
    MS_A2B,
    MS_B2X,
    MS_A2Y,
    MS_TXTX,
    MS_B2P,
    MS_A2B2,
    MS_YMYM,
    MS_A2P,
    MS_B2X3,
    MS_A2Y2,
    MS_B2X2,
    MS_A2Y3
  } mul_sel_t;

  // What to do with the registered product.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_A2,
    ACT_B2,
    ACT_DSTART,
    ACT_TMP,
    ACT_DLOAD,
    ACT_DADD4,
    ACT_DSUB4
  } act_t;

  typedef struct packed {
    mul_sel_t   mul_sel;
    act_t       act;
    logic       load_start;
    logic       inc_x;
    logic       dec_y;
    logic       set_r2;
    logic       emit_load;
    logic [1:0] emit_idx;
  } mer_cmd_t;

  typedef struct packed {
    logic d_neg;
    logic d_zero;
    logic lt;
    logic last_step;
    logic in_r2;
  } mer_sts_t;

endpackage

// File: rtl/core/mer_in_if.sv
// Input channel: start or advance requests with ellipse parameters.
interface mer_in_if;
  import mer_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [AXIS_BITS-1:0]   semi_axis_a;
  logic [AXIS_BITS-1:0]   semi_axis_b;
  logic [COLOR_BITS-1:0]  pixel_color;

  modport source (
    output valid, req_type, center_x, center_y, semi_axis_a, semi_axis_b, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, req_type, center_x, center_y, semi_axis_a, semi_axis_b, pixel_color,
    output ready
  );
endinterface

// File: rtl/core/mer_out_if.sv
// Result channel: plotted points with color and step flags.
interface mer_out_if;
  import mer_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [POINT_BITS-1:0] point_x;
  logic signed [POINT_BITS-1:0] point_y;
  logic [COLOR_BITS-1:0]        point_color;
  logic                         last;
  logic                         done_res;

  modport source (
    output valid, point_x, point_y, point_color, last, done_res,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_color, last, done_res,
    output ready
  );
endinterface

// File: rtl/core/mer_dp.sv
// Datapath: parameter stores, step counters, decision term, shared multiplier, point register.
module mer_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mer_pkg::mer_cmd_t                      cmd,
  output mer_pkg::mer_sts_t                      sts,
  input  logic [mer_pkg::COORD_BITS-1:0]         in_center_x,
  input  logic [mer_pkg::COORD_BITS-1:0]         in_center_y,
  input  logic [mer_pkg::AXIS_BITS-1:0]          in_semi_axis_a,
  input  logic [mer_pkg::AXIS_BITS-1:0]          in_semi_axis_b,
  input  logic [mer_pkg::COLOR_BITS-1:0]         in_pixel_color,
  output logic signed [mer_pkg::POINT_BITS-1:0]  out_point_x,
  output logic signed [mer_pkg::POINT_BITS-1:0]  out_point_y,
  output logic [mer_pkg::COLOR_BITS-1:0]         out_point_color,
  output logic                                   out_last,
  output logic                                   out_done_res
);
  import mer_pkg::*;

  logic [COORD_BITS-1:0]         cx_r, cy_r;
  logic [AXIS_BITS-1:0]          a_r, b_r;
  logic [COLOR_BITS-1:0]         color_r;
  logic [STEP_X_BITS-1:0]        x_r;
  logic signed [STEP_Y_BITS-1:0] y_r;
  logic                          reg2_r;
  logic [SQ_BITS-1:0]            a2_r, b2_r;
  logic signed [DEC_BITS-1:0]    dec_r, tmp_r, prod_r;

  logic signed [POINT_BITS-1:0]  px_r, py_r;
  logic [COLOR_BITS-1:0]         pcol_r;
  logic                          plast_r, pdone_r;

  logic [STEP_X_BITS:0]          tx;
  logic [STEP_X_BITS+1:0]        x3, x2;
  logic signed [STEP_Y_BITS:0]   ym;
  logic signed [YW-1:0]          y_ext, y2, y3;
  logic signed [MUL_W-1:0]       op_p, op_q;
  logic signed [2*MUL_W-1:0]     full_prod;
  logic signed [DEC_BITS-1:0]    dec_nxt;
  logic signed [POINT_BITS-1:0]  cxe, cye, xe, ye, px_nxt, py_nxt;

  assign tx    = {x_r, 1'b1};
  assign x3    = {1'b0, x_r, 1'b0} + (STEP_X_BITS+2)'(3);
  assign x2    = {1'b0, x_r, 1'b0} + (STEP_X_BITS+2)'(2);
  assign ym    = (STEP_Y_BITS+1)'(y_r) - (STEP_Y_BITS+1)'(1);
  assign y_ext = YW'(y_r);
  assign y2    = YW'(2) - (y_ext <<< 1);
  assign y3    = YW'(3) - (y_ext <<< 1);

  // Operand select for the shared multiplier.
  always_comb begin
    op_p = '0;
    op_q = '0;
    case (cmd.mul_sel)
      MS_AA:   begin op_p = MUL_W'(a_r);  op_q = MUL_W'(a_r); end
      MS_BB:   begin op_p = MUL_W'(b_r);  op_q = MUL_W'(b_r); end
      MS_A2B:  begin op_p = MUL_W'(a2_r); op_q = MUL_W'(b_r); end
      MS_B2X:  begin op_p = MUL_W'(b2_r); op_q = MUL_W'(x_r); end
      MS_A2Y:  begin op_p = MUL_W'(a2_r); op_q = MUL_W'(y_r); end
      MS_TXTX: begin op_p = MUL_W'(tx);   op_q = MUL_W'(tx); end
      MS_B2P:  begin op_p = MUL_W'(b2_r); op_q = MUL_W'(prod_r[MUL_W-2:0]); end
      MS_A2B2: begin op_p = MUL_W'(a2_r); op_q = MUL_W'(b2_r); end
      MS_YMYM: begin op_p = MUL_W'(ym);   op_q = MUL_W'(ym); end
      MS_A2P:  begin op_p = MUL_W'(a2_r); op_q = MUL_W'(prod_r[MUL_W-2:0]); end
      MS_B2X3: begin op_p = MUL_W'(b2_r); op_q = MUL_W'(x3); end
      MS_A2Y2: begin op_p = MUL_W'(a2_r); op_q = MUL_W'(y2); end
      MS_B2X2: begin op_p = MUL_W'(b2_r); op_q = MUL_W'(x2); end
      MS_A2Y3: begin op_p = MUL_W'(a2_r); op_q = MUL_W'(y3); end
      default: begin op_p = '0;           op_q = '0; end
    endcase
  end

  assign full_prod = op_p * op_q;

  always_comb begin
    dec_nxt = dec_r;
    case (cmd.act)
      ACT_DSTART: dec_nxt = (DEC_BITS'(b2_r) <<< 2) - (prod_r <<< 2) + DEC_BITS'(a2_r);
      ACT_DLOAD:  dec_nxt = prod_r;
      ACT_DADD4:  dec_nxt = dec_r + (prod_r <<< 2);
      ACT_DSUB4:  dec_nxt = dec_r - (prod_r <<< 2);
      default:    dec_nxt = dec_r;
    endcase
  end

  // Quadrant points: bit 0 of the index mirrors x, bit 1 mirrors y.
  assign cxe    = POINT_BITS'(cx_r);
  assign cye    = POINT_BITS'(cy_r);
  assign xe     = POINT_BITS'(x_r);
  assign ye     = POINT_BITS'(y_r);
  assign px_nxt = cmd.emit_idx[0] ? (cxe - xe) : (cxe + xe);
  assign py_nxt = cmd.emit_idx[1] ? (cye - ye) : (cye + ye);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg2_r <= 1'b0;
    end else if (cmd.load_start) begin
      reg2_r <= 1'b0;
    end else if (cmd.set_r2) begin
      reg2_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= full_prod[DEC_BITS-1:0];
    dec_r  <= dec_nxt;
    if (cmd.act == ACT_A2) begin
      a2_r <= prod_r[SQ_BITS-1:0];
    end
    if (cmd.act == ACT_B2) begin
      b2_r <= prod_r[SQ_BITS-1:0];
    end
    if (cmd.act == ACT_TMP) begin
      tmp_r <= prod_r;
    end
    if (cmd.load_start) begin
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      a_r     <= in_semi_axis_a;
      b_r     <= in_semi_axis_b;
      color_r <= in_pixel_color;
      x_r     <= '0;
      y_r     <= STEP_Y_BITS'(in_semi_axis_b);
    end else begin
      if (cmd.inc_x) begin
        x_r <= x_r + STEP_X_BITS'(1);
      end
      if (cmd.dec_y) begin
        y_r <= y_r - STEP_Y_BITS'(1);
      end
    end
    if (cmd.emit_load) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pcol_r  <= color_r;
      plast_r <= (cmd.emit_idx == 2'd3);
      pdone_r <= sts.last_step;
    end
  end

  assign sts.d_neg     = dec_r[DEC_BITS-1];
  assign sts.d_zero    = (dec_r == '0);
  assign sts.lt        = (tmp_r < prod_r);
  assign sts.last_step = reg2_r && (y_r == '0);
  assign sts.in_r2     = reg2_r;

  assign out_point_x     = px_r;
  assign out_point_y     = py_r;
  assign out_point_color = pcol_r;
  assign out_last        = plast_r;
  assign out_done_res    = pdone_r;

  a_r2_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (reg2_r && !cmd.load_start) |=> reg2_r)
    else $error("region two flag cleared without a start");

endmodule

// File: rtl/core/mer_ctrl.sv
// Controller: sequences start setup, region checks, point emission and decision updates.
module mer_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_req_type,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mer_pkg::mer_sts_t  sts,
  output mer_pkg::mer_cmd_t  cmd
);
  import mer_pkg::*;

  typedef enum logic [20:0] {
    ST_IDLE    = 21'd1 << 0,
    ST_WAIT    = 21'd1 << 1,
    ST_I_AA    = 21'd1 << 2,
    ST_I_BB    = 21'd1 << 3,
    ST_I_AB    = 21'd1 << 4,
    ST_I_DS    = 21'd1 << 5,
    ST_CMP_X   = 21'd1 << 6,
    ST_CMP_Y   = 21'd1 << 7,
    ST_CMP_DEC = 21'd1 << 8,
    ST_R2_BT   = 21'd1 << 9,
    ST_R2_AB   = 21'd1 << 10,
    ST_R2_YM   = 21'd1 << 11,
    ST_R2_AP   = 21'd1 << 12,
    ST_R2_FIN  = 21'd1 << 13,
    ST_EMIT    = 21'd1 << 14,
    ST_U1_A    = 21'd1 << 15,
    ST_U1_B    = 21'd1 << 16,
    ST_U1_C    = 21'd1 << 17,
    ST_U2_A    = 21'd1 << 18,
    ST_U2_B    = 21'd1 << 19,
    ST_U2_C    = 21'd1 << 20
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] emit_cnt_r, emit_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire, slot_free;

  assign in_ready  = (state_r == ST_IDLE) || (state_r == ST_WAIT);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    emit_cnt_nxt   = emit_cnt_r;
    cmd.mul_sel    = MS_NONE;
    cmd.act        = ACT_NONE;
    cmd.load_start = 1'b0;
    cmd.inc_x      = 1'b0;
    cmd.dec_y      = 1'b0;
    cmd.set_r2     = 1'b0;
    cmd.emit_load  = 1'b0;
    cmd.emit_idx   = emit_cnt_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_req_type == REQ_START) begin
          cmd.load_start = 1'b1;
          state_nxt      = ST_I_AA;
        end
      end
      ST_WAIT: begin
        if (in_fire) begin
          if (in_req_type == REQ_START) begin
            cmd.load_start = 1'b1;
            state_nxt      = ST_I_AA;
          end else begin
            emit_cnt_nxt = '0;
            state_nxt    = ST_EMIT;
          end
        end
      end
      ST_I_AA: begin
        cmd.mul_sel = MS_AA;
        state_nxt   = ST_I_BB;
      end
      ST_I_BB: begin
        cmd.mul_sel = MS_BB;
        cmd.act     = ACT_A2;
        state_nxt   = ST_I_AB;
      end
      ST_I_AB: begin
        cmd.mul_sel = MS_A2B;
        cmd.act     = ACT_B2;
        state_nxt   = ST_I_DS;
      end
      ST_I_DS: begin
        cmd.mul_sel = MS_B2X;
        cmd.act     = ACT_DSTART;
        state_nxt   = ST_CMP_Y;
      end
      ST_CMP_X: begin
        cmd.mul_sel = MS_B2X;
        state_nxt   = ST_CMP_Y;
      end
      ST_CMP_Y: begin
        cmd.mul_sel = MS_A2Y;
        cmd.act     = ACT_TMP;
        state_nxt   = ST_CMP_DEC;
      end
      ST_CMP_DEC: begin
        if (sts.lt) begin
          state_nxt = ST_WAIT;
        end else begin
          cmd.mul_sel = MS_TXTX;
          state_nxt   = ST_R2_BT;
        end
      end
      ST_R2_BT: begin
        cmd.mul_sel = MS_B2P;
        state_nxt   = ST_R2_AB;
      end
      ST_R2_AB: begin
        cmd.mul_sel = MS_A2B2;
        cmd.act     = ACT_DLOAD;
        state_nxt   = ST_R2_YM;
      end
      ST_R2_YM: begin
        cmd.mul_sel = MS_YMYM;
        cmd.act     = ACT_DSUB4;
        state_nxt   = ST_R2_AP;
      end
      ST_R2_AP: begin
        cmd.mul_sel = MS_A2P;
        state_nxt   = ST_R2_FIN;
      end
      ST_R2_FIN: begin
        cmd.act    = ACT_DADD4;
        cmd.set_r2 = 1'b1;
        state_nxt  = ST_WAIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit_load = 1'b1;
          emit_cnt_nxt  = emit_cnt_r + 2'd1;
          if (emit_cnt_r == 2'd3) begin
            if (sts.last_step) begin
              state_nxt = ST_IDLE;
            end else if (sts.in_r2) begin
              state_nxt = ST_U2_A;
            end else begin
              state_nxt = ST_U1_A;
            end
          end
        end
      end
      ST_U1_A: begin
        cmd.mul_sel = MS_B2X3;
        state_nxt   = ST_U1_B;
      end
      ST_U1_B: begin
        cmd.act = ACT_DADD4;
        if (sts.d_neg) begin
          cmd.inc_x = 1'b1;
          state_nxt = ST_CMP_X;
        end else begin
          cmd.mul_sel = MS_A2Y2;
          state_nxt   = ST_U1_C;
        end
      end
      ST_U1_C: begin
        cmd.act   = ACT_DADD4;
        cmd.inc_x = 1'b1;
        cmd.dec_y = 1'b1;
        state_nxt = ST_CMP_X;
      end
      ST_U2_A: begin
        cmd.mul_sel = MS_A2Y3;
        state_nxt   = ST_U2_B;
      end
      ST_U2_B: begin
        cmd.act = ACT_DADD4;
        if (!sts.d_neg && !sts.d_zero) begin
          cmd.dec_y = 1'b1;
          state_nxt = ST_WAIT;
        end else begin
          cmd.mul_sel = MS_B2X2;
          state_nxt   = ST_U2_C;
        end
      end
      ST_U2_C: begin
        cmd.act   = ACT_DADD4;
        cmd.inc_x = 1'b1;
        cmd.dec_y = 1'b1;
        state_nxt = ST_WAIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_adv_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req_type == REQ_ADVANCE && state_r == ST_WAIT) |=> !in_ready)
    else $error("input still open after an advance was taken");

  a_emit_four: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && emit_cnt_r == 2'd3) |=> (state_r != ST_EMIT))
    else $error("emission continued past the fourth point");

  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (emit_cnt_r == 2'd0))
    else $error("point counter not clear while waiting for a request");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> !$past(cmd.emit_load))
    else $error("point register overwritten while stalled");

endmodule

// File: rtl/core/midpoint_ellipse_rasterizer_unit.sv
// Top level of the midpoint ellipse rasterizer: controller, datapath and channel hookup.
//
//  Channel | Dir | Handshake            | Payload
//  in_ch   | in  | valid/ready transfer | req_type, center_x/y, semi_axis_a/b, pixel_color
//  out_ch  | out | valid/ready transfer | point_x, point_y, point_color, last, done_res
//
//  Start: setup on the shared multiplier, plus the region-two setup when the ellipse
//    begins in region two; the block takes no request meanwhile and emits nothing.
//  Advance: accept, four point emissions and a decision update, plus a region test
//    in region one and the region-two setup on the switch to region two; the final
//    step skips the update. The single multiplier yields one product per cycle.
//  Reset (rst_n low, synchronous) returns the block to idle with the result empty.
//  A stalled out_ch holds the point register; the next point waits for its transfer.
module midpoint_ellipse_rasterizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  mer_in_if.sink     in_ch,
  mer_out_if.source  out_ch
);
  import mer_pkg::*;

  mer_cmd_t cmd;
  mer_sts_t sts;

  // Sequencer: owns the handshakes and issues one command word per cycle.
  mer_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Arithmetic and storage: decision term, step counters and the point register.
  mer_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_center_x     (in_ch.center_x),
    .in_center_y     (in_ch.center_y),
    .in_semi_axis_a  (in_ch.semi_axis_a),
    .in_semi_axis_b  (in_ch.semi_axis_b),
    .in_pixel_color  (in_ch.pixel_color),
    .out_point_x     (out_ch.point_x),
    .out_point_y     (out_ch.point_y),
    .out_point_color (out_ch.point_color),
    .out_last        (out_ch.last),
    .out_done_res    (out_ch.done_res)
  );

endmodule
